>>> hw/rtl/moving_mean_order_fit_defines.svh
// Assertion helpers for the moving-mean order fit block.
`ifndef MOVING_MEAN_ORDER_FIT_DEFINES_SVH
`define MOVING_MEAN_ORDER_FIT_DEFINES_SVH

// Check a property on every rising clock edge outside reset.
`define MMOF_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Check that a condition never holds outside reset.
`define MMOF_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  `MMOF_ASSERT(lbl, clk, rst_n, !(cond), msg)

`endif

>>> hw/rtl/mmof_pkg.sv
package mmof_pkg;

  localparam int SAMPLE_BITS    = 16;
  localparam int MAX_ORDER_DEF  = 16;
  localparam int MAX_LENGTH_DEF = 1048576;

  localparam int FRAC_W      = 16;
  localparam int RECIP_W     = 17;
  localparam int RECIP_IDX_W = 6;
  localparam int MEAN_W      = SAMPLE_BITS + 1;
  localparam int PRED_W      = SAMPLE_BITS + 1;
  localparam int D_W         = SAMPLE_BITS + 2;
  localparam int MAG_W       = SAMPLE_BITS + 1;
  localparam int SQ_W        = 2 * MAG_W;
  localparam int TOT_W       = 53;
  localparam int VAR_W       = 33;
  localparam int ORDER_W     = 5;
  localparam int CFG_W       = 5;

  localparam int IN_DATA_W   = 16;
  localparam int OUT_DATA_W  = 40;
  localparam int OUT_PAD_W   = OUT_DATA_W - ORDER_W - VAR_W;

  localparam int APB_ADDR_W  = 3;
  localparam int APB_DATA_W  = 32;
  localparam int REG_IDX_W   = APB_ADDR_W - 2;

  localparam logic [REG_IDX_W-1:0] REG_MAX_ORDER = 1'b0;
  localparam logic [CFG_W-1:0]     MAX_ORDER_RST = 5'd16;

  // round(65536 / k) for k = 1 .. 64, entry k-1
  localparam logic [RECIP_W-1:0] RECIP [2**RECIP_IDX_W] = '{
    17'd65536, 17'd32768, 17'd21845, 17'd16384, 17'd13107, 17'd10923, 17'd9362,  17'd8192,
    17'd7282,  17'd6554,  17'd5958,  17'd5461,  17'd5041,  17'd4681,  17'd4369,  17'd4096,
    17'd3855,  17'd3641,  17'd3449,  17'd3277,  17'd3121,  17'd2979,  17'd2849,  17'd2731,
    17'd2621,  17'd2521,  17'd2427,  17'd2341,  17'd2260,  17'd2185,  17'd2114,  17'd2048,
    17'd1986,  17'd1928,  17'd1872,  17'd1820,  17'd1771,  17'd1725,  17'd1680,  17'd1638,
    17'd1598,  17'd1560,  17'd1524,  17'd1489,  17'd1456,  17'd1425,  17'd1394,  17'd1365,
    17'd1337,  17'd1311,  17'd1285,  17'd1260,  17'd1237,  17'd1214,  17'd1192,  17'd1170,
    17'd1150,  17'd1130,  17'd1111,  17'd1092,  17'd1074,  17'd1057,  17'd1040,  17'd1024
  };

  function automatic logic [TOT_W-1:0] sat_add(logic [TOT_W-1:0] a, logic [TOT_W-1:0] b);
    logic [TOT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TOT_W] ? {TOT_W{1'b1}} : s[TOT_W-1:0];
  endfunction

endpackage

>>> hw/rtl/moving_mean_order_fit.sv
// Moving-mean order fit. Takes a run of signed Q8.8 samples (tlast marks the
// final one) and scores one-step prediction for every window order 1..MAX_ORDER;
// on the final sample it returns the order with the least total squared error
// (lowest order on a tie) and that total divided by the run length. For each
// sample other than the first of a run, one pipelined predict-and-square unit
// scores one order per cycle while the window rotates past it. A final sample
// adds two passes of a bit-serial divider (the run mean, then the error
// variance) and a search over the orders up to the configured order limit.
// No input is taken while an item is in work; a result waits in the output
// register until taken, and the next result is held back until then.
module moving_mean_order_fit #(
  parameter int MAX_ORDER  = mmof_pkg::MAX_ORDER_DEF,
  parameter int MAX_LENGTH = mmof_pkg::MAX_LENGTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  input  logic [mmof_pkg::IN_DATA_W-1:0]      s_axis_tdata_i,  // [15:0] sample
  input  logic                                s_axis_tlast_i,  // last_sample
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // [4:0] best_order, [37:5] error_variance, [39:38] zero
  output logic [mmof_pkg::OUT_DATA_W-1:0]     m_axis_tdata_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [mmof_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [mmof_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [mmof_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready
);

  localparam int SB     = mmof_pkg::SAMPLE_BITS;
  localparam int IDX_W  = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
  localparam int K_W    = $clog2(MAX_ORDER + 3);
  localparam int LIM_W  = (K_W > mmof_pkg::CFG_W) ? K_W : mmof_pkg::CFG_W;
  localparam int SUM_W  = SB + $clog2(MAX_ORDER) + 1;
  localparam int CNT_W  = $clog2(MAX_LENGTH + 1);
  localparam int RSUM_W = SB + CNT_W;
  localparam int TOT_W  = mmof_pkg::TOT_W;
  localparam int VAR_W  = mmof_pkg::VAR_W;
  localparam int MEAN_W = mmof_pkg::MEAN_W;
  localparam int SQ_W   = mmof_pkg::SQ_W;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SCORE  = 3'd1;
  localparam logic [2:0] ST_UPDATE = 3'd2;
  localparam logic [2:0] ST_MEAN   = 3'd3;
  localparam logic [2:0] ST_FERR   = 3'd4;
  localparam logic [2:0] ST_SEARCH = 3'd5;
  localparam logic [2:0] ST_VAR    = 3'd6;
  localparam logic [2:0] ST_RESULT = 3'd7;

  logic [2:0]                   state_q, state_d;
  logic [K_W-1:0]               k_q, k_d;
  logic signed [SUM_W-1:0]      acc_q, acc_d;
  logic [CNT_W-1:0]             count_q, count_d;
  logic signed [RSUM_W-1:0]     rsum_q, rsum_d;
  logic signed [SB-1:0]         first_q, first_d;
  logic signed [SB-1:0]         taps_q [MAX_ORDER];
  logic signed [SB-1:0]         taps_d [MAX_ORDER];
  logic [MAX_ORDER-1:0]         tot_vld_q, tot_vld_d;
  logic                         start_q, start_d;
  logic                         srch_vld_q, srch_vld_d;
  logic [K_W-1:0]               srch_k_q, srch_k_d;
  logic [K_W-1:0]               best_k_q, best_k_d;
  logic [TOT_W-1:0]             best_tot_q, best_tot_d;
  logic                         m_vld_q, m_vld_d;
  logic [mmof_pkg::CFG_W-1:0]   max_order_q;

  logic signed [SB-1:0]         x_q;
  logic                         last_q;
  logic signed [MEAN_W-1:0]     mean_q, mean_d;
  logic [SQ_W-1:0]              ferr_q, ferr_d;
  logic [VAR_W-1:0]             var_hold_q, var_hold_d;
  logic [mmof_pkg::ORDER_W-1:0] res_order_q, res_order_d;
  logic [VAR_W-1:0]             res_var_q, res_var_d;
  logic [TOT_W-1:0]             rd_q;
  logic [TOT_W-1:0]             tot_mem [MAX_ORDER];

  logic                         in_acc;
  logic                         sc_vld;
  logic signed [SUM_W-1:0]      sc_sum;
  logic [mmof_pkg::RECIP_W-1:0] sc_recip;
  logic signed [SB-1:0]         sc_x;
  logic [IDX_W-1:0]             mid_idx;
  logic                         sq_vld;
  logic [IDX_W-1:0]             sq_idx;
  logic [SQ_W-1:0]              sq;
  logic                         wr_en;
  logic [TOT_W-1:0]             wr_data;
  logic [IDX_W-1:0]             rd_idx;
  logic [TOT_W-1:0]             div_num;
  logic [CNT_W-1:0]             len;
  logic                         div_done;
  logic [TOT_W-1:0]             div_quo;
  logic [CNT_W-1:0]             div_rem;
  logic                         rsum_neg;
  logic [RSUM_W-1:0]            rsum_abs;
  logic signed [MEAN_W-1:0]     q_s;
  logic signed [MEAN_W-1:0]     mean_calc;
  logic [LIM_W-1:0]             cfg_ext;
  logic [LIM_W-1:0]             lim;
  logic                         srch_issue;
  logic [TOT_W-1:0]             srch_t;
  logic                         cfg_wr;

  // ---------------------------------------------------------------- config
  assign cfg_wr = psel & penable & pwrite & pready;
  assign pready = 1'b1;
  assign prdata = (paddr[mmof_pkg::APB_ADDR_W-1:2] == mmof_pkg::REG_MAX_ORDER)
                  ? mmof_pkg::APB_DATA_W'(max_order_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_order_q <= mmof_pkg::MAX_ORDER_RST;
    end else if (cfg_wr && paddr[mmof_pkg::APB_ADDR_W-1:2] == mmof_pkg::REG_MAX_ORDER) begin
      max_order_q <= pwdata[mmof_pkg::CFG_W-1:0];
    end
  end

  always_comb begin
    cfg_ext = LIM_W'(max_order_q);
    if (cfg_ext == '0) begin
      lim = LIM_W'(1);
    end else if (cfg_ext > LIM_W'(MAX_ORDER)) begin
      lim = LIM_W'(MAX_ORDER);
    end else begin
      lim = cfg_ext;
    end
  end

  // ---------------------------------------------------------------- datapath
  assign in_acc = s_axis_tvalid_i & s_axis_tready_o;
  assign s_axis_tready_o = (state_q == ST_IDLE);

  always_comb begin
    sc_vld   = ((state_q == ST_SCORE) && (k_q < K_W'(MAX_ORDER))) ||
               ((state_q == ST_FERR) && (k_q == '0));
    if (state_q == ST_FERR) begin
      sc_sum   = SUM_W'(mean_q);
      sc_recip = mmof_pkg::RECIP[0];
      sc_x     = first_q;
    end else begin
      sc_sum   = acc_q + SUM_W'(taps_q[0]);
      sc_recip = mmof_pkg::RECIP[mmof_pkg::RECIP_IDX_W'(k_q[IDX_W-1:0])];
      sc_x     = x_q;
    end
  end

  mmof_score #(
    .SUM_W (SUM_W),
    .IDX_W (IDX_W)
  ) u_score (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_vld_i   (sc_vld),
    .in_idx_i   (k_q[IDX_W-1:0]),
    .in_sum_i   (sc_sum),
    .in_recip_i (sc_recip),
    .in_x_i     (sc_x),
    .mid_idx_o  (mid_idx),
    .sq_vld_o   (sq_vld),
    .sq_idx_o   (sq_idx),
    .sq_o       (sq)
  );

  assign rd_idx  = (state_q == ST_SEARCH) ? k_q[IDX_W-1:0] : mid_idx;
  assign wr_en   = (state_q == ST_SCORE) && sq_vld;
  assign wr_data = mmof_pkg::sat_add(rd_q, TOT_W'(sq));

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      tot_mem[sq_idx] <= wr_data;
    end
    rd_q <= tot_vld_q[rd_idx] ? tot_mem[rd_idx] : '0;
  end

  assign len      = (count_q == '0) ? CNT_W'(1) : count_q;
  assign rsum_neg = rsum_q[RSUM_W-1];
  assign rsum_abs = rsum_neg ? -rsum_q : rsum_q;
  assign div_num  = (state_q == ST_VAR) ? best_tot_q : TOT_W'(rsum_abs);

  mmof_div #(
    .NUM_W (TOT_W),
    .DEN_W (CNT_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_q),
    .num_i   (div_num),
    .den_i   (len),
    .done_o  (div_done),
    .quo_o   (div_quo),
    .rem_o   (div_rem)
  );

  always_comb begin
    q_s       = $signed(div_quo[MEAN_W-1:0]);
    mean_calc = rsum_neg ? (-q_s - MEAN_W'(div_rem != '0)) : q_s;
  end

  assign srch_issue = (LIM_W'(k_q) < lim);
  assign srch_t     = mmof_pkg::sat_add(rd_q, TOT_W'(ferr_q));

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_d     = state_q;
    k_d         = k_q;
    acc_d       = acc_q;
    count_d     = count_q;
    rsum_d      = rsum_q;
    first_d     = first_q;
    taps_d      = taps_q;
    tot_vld_d   = tot_vld_q;
    start_d     = 1'b0;
    srch_vld_d  = 1'b0;
    srch_k_d    = srch_k_q;
    best_k_d    = best_k_q;
    best_tot_d  = best_tot_q;
    m_vld_d     = m_vld_q & ~m_axis_tready_i;
    mean_d      = mean_q;
    ferr_d      = ferr_q;
    var_hold_d  = var_hold_q;
    res_order_d = res_order_q;
    res_var_d   = res_var_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          k_d   = '0;
          acc_d = '0;
          if (count_q < CNT_W'(MAX_LENGTH)) begin
            if (count_q == '0) begin
              first_d = $signed(s_axis_tdata_i[SB-1:0]);
              state_d = ST_UPDATE;
            end else begin
              state_d = ST_SCORE;
            end
          end else if (s_axis_tlast_i) begin
            state_d = ST_MEAN;
            start_d = 1'b1;
          end
        end
      end
      ST_SCORE: begin
        k_d = k_q + K_W'(1);
        if (sc_vld) begin
          acc_d = sc_sum;
          for (int j = 0; j < MAX_ORDER - 1; j++) begin
            taps_d[j] = taps_q[j+1];
          end
          taps_d[MAX_ORDER-1] = taps_q[0];
        end
        if (wr_en) begin
          tot_vld_d[sq_idx] = 1'b1;
        end
        if (k_q == K_W'(MAX_ORDER + 1)) begin
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        taps_d[0] = x_q;
        for (int j = 1; j < MAX_ORDER; j++) begin
          taps_d[j] = taps_q[j-1];
        end
        count_d = count_q + CNT_W'(1);
        rsum_d  = rsum_q + RSUM_W'(x_q);
        if (last_q) begin
          state_d = ST_MEAN;
          start_d = 1'b1;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_MEAN: begin
        if (div_done) begin
          mean_d  = mean_calc;
          k_d     = '0;
          state_d = ST_FERR;
        end
      end
      ST_FERR: begin
        k_d = k_q + K_W'(1);
        if (sq_vld) begin
          ferr_d  = sq;
          k_d     = '0;
          state_d = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (srch_vld_q && ((srch_k_q == '0) || (srch_t < best_tot_q))) begin
          best_tot_d = srch_t;
          best_k_d   = srch_k_q + K_W'(1);
        end
        if (srch_issue) begin
          k_d        = k_q + K_W'(1);
          srch_vld_d = 1'b1;
          srch_k_d   = k_q;
        end else begin
          state_d = ST_VAR;
          start_d = 1'b1;
        end
      end
      ST_VAR: begin
        if (div_done) begin
          var_hold_d = (div_quo[TOT_W-1:VAR_W] != '0) ? {VAR_W{1'b1}}
                                                       : div_quo[VAR_W-1:0];
          state_d    = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (!m_vld_q) begin
          m_vld_d     = 1'b1;
          res_order_d = mmof_pkg::ORDER_W'(best_k_q);
          res_var_d   = var_hold_q;
          for (int j = 0; j < MAX_ORDER; j++) begin
            taps_d[j] = '0;
          end
          tot_vld_d = '0;
          count_d   = '0;
          rsum_d    = '0;
          first_d   = '0;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      k_q        <= '0;
      acc_q      <= '0;
      count_q    <= '0;
      rsum_q     <= '0;
      first_q    <= '0;
      for (int j = 0; j < MAX_ORDER; j++) begin
        taps_q[j] <= '0;
      end
      tot_vld_q  <= '0;
      start_q    <= 1'b0;
      srch_vld_q <= 1'b0;
      srch_k_q   <= '0;
      best_k_q   <= K_W'(1);
      best_tot_q <= '0;
      m_vld_q    <= 1'b0;
    end else begin
      state_q    <= state_d;
      k_q        <= k_d;
      acc_q      <= acc_d;
      count_q    <= count_d;
      rsum_q     <= rsum_d;
      first_q    <= first_d;
      taps_q     <= taps_d;
      tot_vld_q  <= tot_vld_d;
      start_q    <= start_d;
      srch_vld_q <= srch_vld_d;
      srch_k_q   <= srch_k_d;
      best_k_q   <= best_k_d;
      best_tot_q <= best_tot_d;
      m_vld_q    <= m_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      x_q    <= $signed(s_axis_tdata_i[SB-1:0]);
      last_q <= s_axis_tlast_i;
    end
    mean_q      <= mean_d;
    ferr_q      <= ferr_d;
    var_hold_q  <= var_hold_d;
    res_order_q <= res_order_d;
    res_var_q   <= res_var_d;
  end

  assign m_axis_tvalid_o = m_vld_q;
  assign m_axis_tdata_o  = {{mmof_pkg::OUT_PAD_W{1'b0}}, res_var_q, res_order_q};

endmodule

>>> hw/rtl/mmof_score.sv
module mmof_score #(
  parameter int SUM_W = 21,
  parameter int IDX_W = 4
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_vld_i,
  input  logic [IDX_W-1:0]                     in_idx_i,
  input  logic signed [SUM_W-1:0]              in_sum_i,
  input  logic [mmof_pkg::RECIP_W-1:0]         in_recip_i,
  input  logic signed [mmof_pkg::SAMPLE_BITS-1:0] in_x_i,
  output logic [IDX_W-1:0]                     mid_idx_o,
  output logic                                 sq_vld_o,
  output logic [IDX_W-1:0]                     sq_idx_o,
  output logic [mmof_pkg::SQ_W-1:0]            sq_o
);

  localparam int PROD_W = SUM_W + mmof_pkg::RECIP_W + 1;

  logic                                    p_vld_q;
  logic [IDX_W-1:0]                        p_idx_q;
  logic signed [PROD_W-1:0]                prod_q;
  logic signed [mmof_pkg::SAMPLE_BITS-1:0] px_q;
  logic                                    s_vld_q;
  logic [IDX_W-1:0]                        s_idx_q;
  logic [mmof_pkg::SQ_W-1:0]               sq_q;

  logic signed [PROD_W-1:0]              prod;
  logic signed [mmof_pkg::PRED_W-1:0]    pred;
  logic signed [mmof_pkg::D_W-1:0]       diff;
  logic signed [mmof_pkg::D_W-1:0]       diff_abs;
  logic [mmof_pkg::MAG_W-1:0]            mag;
  logic [mmof_pkg::SQ_W-1:0]             sq;

  always_comb begin
    prod     = in_sum_i * $signed({1'b0, in_recip_i});
    pred     = $signed(prod_q[mmof_pkg::FRAC_W +: mmof_pkg::PRED_W]);
    diff     = mmof_pkg::D_W'(px_q) - mmof_pkg::D_W'(pred);
    diff_abs = diff[mmof_pkg::D_W-1] ? -diff : diff;
    mag      = diff_abs[mmof_pkg::MAG_W-1:0];
    sq       = mag * mag;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_vld_q <= 1'b0;
      s_vld_q <= 1'b0;
    end else begin
      p_vld_q <= in_vld_i;
      s_vld_q <= p_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    p_idx_q <= in_idx_i;
    prod_q  <= prod;
    px_q    <= in_x_i;
    s_idx_q <= p_idx_q;
    sq_q    <= sq;
  end

  assign mid_idx_o = p_idx_q;
  assign sq_vld_o  = s_vld_q;
  assign sq_idx_o  = s_idx_q;
  assign sq_o      = sq_q;

endmodule

>>> hw/rtl/mmof_div.sv
module mmof_div #(
  parameter int NUM_W = 53,
  parameter int DEN_W = 21
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quo_o,
  output logic [DEN_W-1:0] rem_o
);

  localparam int CTR_W = $clog2(NUM_W + 1);

  logic             busy_q;
  logic             done_q;
  logic [CTR_W-1:0] cnt_q;
  logic [NUM_W-1:0] quo_q;
  logic [DEN_W-1:0] rem_q;
  logic [DEN_W-1:0] den_q;

  logic [DEN_W:0]   shifted;
  logic [DEN_W:0]   diff;
  logic             ge;

  always_comb begin
    shifted = {rem_q, quo_q[NUM_W-1]};
    diff    = shifted - {1'b0, den_q};
    ge      = shifted >= {1'b0, den_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CTR_W'(NUM_W);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CTR_W'(1);
      if (cnt_q == CTR_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[NUM_W-2:0], ge};
      rem_q <= ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule

>>> hw/rtl/mmof_checker.sv
`include "moving_mean_order_fit_defines.svh"

module mmof_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tready_o,
  input logic                            m_axis_tvalid_o,
  input logic                            m_axis_tready_i,
  input logic [mmof_pkg::OUT_DATA_W-1:0] m_axis_tdata_o
);

  `MMOF_ASSERT(a_out_hold, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o), "result changed while stalled")
  `MMOF_ASSERT(a_rise_after_busy, clk_i, rst_ni, $rose(m_axis_tvalid_o) |-> $past(!s_axis_tready_o), "result appeared without work")
  `MMOF_ASSERT(a_gap_after_take, clk_i, rst_ni, m_axis_tvalid_o && m_axis_tready_i |=> !m_axis_tvalid_o, "result repeated after take")
  `MMOF_ASSERT_NEVER(a_order_zero, clk_i, rst_ni, m_axis_tvalid_o && (m_axis_tdata_o[mmof_pkg::ORDER_W-1:0] == '0), "best order is zero")

endmodule

bind moving_mean_order_fit mmof_checker u_mmof_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);
